// ===== design/sarg_pkg.sv =====
`timescale 1ns / 1ps

package sarg_pkg;

    // Default sizes of the position counter and of the period fraction.
    localparam int POSITION_BITS_DEF    = 32;
    localparam int PERIOD_FRAC_BITS_DEF = 8;

    // Widths fixed by the field formats.
    localparam int PERIOD_US_BITS = 16;
    localparam int SPEED_BITS     = 20;
    localparam int SQ_BITS        = 2 * SPEED_BITS;
    localparam int ACC_BITS       = 20;
    localparam int IDX_BITS       = 32;
    localparam int ELA_BITS       = 16;
    localparam int IN_DATA_BITS   = 32;
    localparam int OUT_DATA_BITS  = 40;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 20;

    localparam longint unsigned US_PER_S = 64'd1000000;
    localparam logic signed [IDX_BITS-1:0] IDX_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ABSOLUTE_MODE = 3'd0,
        CFG_START_PERIOD  = 3'd1,
        CFG_MIN_PERIOD    = 3'd2,
        CFG_ACCELERATION  = 3'd3,
        CFG_DRIVE_ENABLE  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_SQ,
        ST_PTS_GO,
        ST_PTS_WAIT,
        ST_DEC,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_FIN
    } state_t;

endpackage

// ===== design/sarg_div.sv =====
`timescale 1ns / 1ps

// Restoring divider that retires one quotient bit per cycle.
module sarg_div #(
    parameter int N = 40,
    parameter int D = 34
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CW = $clog2(N + 1);

    logic [D-1:0]  rem_reg, rem_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CW'(N);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[D-1:0] : trial[D-1:0];
            quo_next = {quo_reg[N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/stepper_accel_ramp_generator.sv =====
`timescale 1ns / 1ps

// Stepper step generator with a trapezoidal speed ramp.
// Requests arrive on the slave stream: tuser carries the opcode (tick of one
// microsecond, start move, stop move, no operation), tdata the signed move amount. Every
// request yields exactly one result on the master stream. Configuration is
// written through the cfg channel (index, data), which is always ready and is
// meant to be used only while no request is in flight.
// A request that does not run the ramp update is answered in the cycle after it
// is accepted. A tick that issues a step, and a start with the drive enabled,
// run the ramp update on one shared bit-serial divider: speed (skipped when the
// period is zero), square, stopping distance, phase decision, period update and
// a final state that loads the result. The period division is skipped when the
// ramp restarts from rest or ends. A start with the drive enabled needs only the
// stopping distance division.
// Requests are taken one at a time; the next one is accepted once the result
// register is empty or is being taken in the same cycle, so a stalled
// receiver holds off new requests but never loses a result.
// Reset clears position, target, period and ramp index, sets the direction
// positive, marks the drive idle and loads the register defaults.
module stepper_accel_ramp_generator #(
    parameter int POSITION_BITS    = sarg_pkg::POSITION_BITS_DEF,
    parameter int PERIOD_FRAC_BITS = sarg_pkg::PERIOD_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // move_amount [31:0]
    input  logic [sarg_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // opcode [1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // step_pulse [0], dir_positive [1], position [33:2], moving [34],
    // move_done [35], move_aborted [36], zero fill [39:37]
    output logic [sarg_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sarg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [sarg_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int P   = POSITION_BITS;
    localparam int F   = PERIOD_FRAC_BITS;
    localparam int PW  = sarg_pkg::PERIOD_US_BITS + F;
    localparam int SNW = sarg_pkg::SPEED_BITS + F;
    localparam int SQW = sarg_pkg::SQ_BITS;
    localparam int DN  = (SNW > SQW) ? SNW : SQW;
    localparam int DD  = (PW > 34) ? PW : 34;
    localparam int CW  = (P > SQW) ? P : SQW;
    localparam int IW  = sarg_pkg::IDX_BITS;
    localparam int EW  = sarg_pkg::ELA_BITS;
    localparam int AW  = sarg_pkg::ACC_BITS;

    localparam logic [SNW-1:0] SPD_NUM = SNW'(sarg_pkg::US_PER_S << F);
    localparam logic [PW-1:0]  PMAX    = {16'hFFFF, {F{1'b0}}};

    // Configuration registers.
    logic          abs_reg;
    logic [15:0]   sp_reg;
    logic [15:0]   mp_reg;
    logic [AW-1:0] acc_reg;
    logic          en_reg;

    // Move state.
    logic [P-1:0]         pos_reg, pos_next;
    logic [P-1:0]         tgt_reg, tgt_next;
    logic [PW-1:0]        per_reg, per_next;
    logic signed [IW-1:0] idx_reg, idx_next;
    logic [EW-1:0]        ela_reg, ela_next;
    logic                 dir_reg, dir_next;
    logic                 busy_reg, busy_next;

    // Ramp update working registers.
    logic [sarg_pkg::SPEED_BITS-1:0] spd_reg, spd_next;
    logic [SQW-1:0]                  sq_reg, sq_next;
    logic [SQW-1:0]                  pts_reg, pts_next;
    logic signed [IW-1:0]            n_reg, n_next;
    logic                            isst_reg, isst_next;

    logic                                ov_reg, ov_next;
    logic [sarg_pkg::OUT_DATA_BITS-1:0]  od_reg, od_next;

    sarg_pkg::state_t state_reg, state_next;

    logic           accept;
    sarg_pkg::op_t  op;
    logic [63:0]    amt_w;
    logic [EW-1:0]  ela_inc;
    logic           step_due;
    logic           go_ramp;
    logic           out_load;
    logic           done_f;
    logic           abrt_f;
    logic           step_f;

    logic [15:0]    spu;
    logic [15:0]    mpu;
    logic [AW:0]    acc2;

    logic [P-1:0]   diff;
    logic           tg_neg;
    logic           tg_zero;
    logic [P-1:0]   mag;
    logic           sq_small;
    logic           pts_ge;
    logic signed [IW-1:0] ptsc;
    logic           with_dir;
    logic signed [IW-1:0] dec_n;
    logic           dec_early;

    logic signed [IW+2:0] d4;
    logic [IW+1:0]  ad;
    logic           d_pos;

    logic           div_start;
    logic [DN-1:0]  div_a;
    logic [DD-1:0]  div_b;
    logic           div_done;
    logic [DN-1:0]  div_q;

    logic [PW+1:0]  pe;
    logic [PW+1:0]  qe;
    logic [PW+1:0]  pnew;
    logic [PW+1:0]  lo;
    logic [63:0]    pos_w;

    sarg_div #(
        .N (DN),
        .D (DD)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == sarg_pkg::ST_IDLE) && (!ov_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign op        = sarg_pkg::op_t'(s_tuser);
    assign amt_w     = {{32{s_tdata[31]}}, s_tdata};
    assign m_tvalid  = ov_reg;
    assign m_tdata   = od_reg;

    // Zero in a rate register is treated as one.
    assign spu  = (sp_reg == '0) ? 16'd1 : sp_reg;
    assign mpu  = (mp_reg == '0) ? 16'd1 : mp_reg;
    assign acc2 = {((acc_reg == '0) ? AW'(1) : acc_reg), 1'b0};

    assign ela_inc  = (ela_reg == {EW{1'b1}}) ? ela_reg : ela_reg + 1'b1;
    assign step_due = {ela_inc, {F{1'b0}}} >= per_reg;
    assign go_ramp  = en_reg && ((op == sarg_pkg::OP_START) ||
                      ((op == sarg_pkg::OP_TICK) && busy_reg && step_due));

    // Distance to go, read as a signed count.
    assign diff    = tgt_reg - pos_reg;
    assign tg_neg  = diff[P-1];
    assign tg_zero = (diff == '0);
    assign mag     = tg_neg ? (P'(0) - diff) : diff;

    assign sq_small = sq_reg <= SQW'(acc2);
    assign pts_ge   = CW'(pts_reg) >= CW'(mag);
    assign ptsc     = (pts_reg[SQW-1:IW-1] != '0) ? sarg_pkg::IDX_MAX
                                                  : {1'b0, pts_reg[IW-2:0]};
    assign with_dir = (!tg_neg) == dir_reg;

    // Ramp phase decision: a positive index accelerates, a negative one
    // decelerates, zero restarts from rest.
    always_comb
    begin
        dec_n     = idx_reg;
        dec_early = tg_zero && sq_small;
        if (!tg_zero)
        begin
            if (idx_reg > 0)
            begin
                if (pts_ge || !with_dir)
                begin
                    dec_n = -ptsc;
                end
            end
            else if (idx_reg < 0)
            begin
                if (!pts_ge && with_dir)
                begin
                    dec_n = -idx_reg;
                end
            end
        end
    end

    // Divisor of the Austin update, 4n + 1, which is never zero.
    assign d4    = {n_reg[IW-1], n_reg, 2'b01};
    assign d_pos = !d4[IW+2];
    assign ad    = d_pos ? d4[IW+1:0] : (IW+2)'(-d4);

    assign pe = {2'b00, per_reg};
    assign qe = {1'b0, div_q[PW:0]};
    assign lo = (PW+2)'({mpu, {F{1'b0}}});

    always_comb
    begin
        pnew = d_pos ? ((qe > pe) ? '0 : pe - qe) : pe + qe;
        if (pnew < lo)
        begin
            pnew = lo;
        end
        if (pnew > (PW+2)'(PMAX))
        begin
            pnew = (PW+2)'(PMAX);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sarg_pkg::ST_IDLE:
            begin
                if (accept && go_ramp)
                begin
                    state_next = sarg_pkg::ST_SPD_GO;
                end
            end
            sarg_pkg::ST_SPD_GO:
            begin
                state_next = (per_reg == '0) ? sarg_pkg::ST_SQ : sarg_pkg::ST_SPD_WAIT;
            end
            sarg_pkg::ST_SPD_WAIT:
            begin
                if (div_done)
                begin
                    state_next = sarg_pkg::ST_SQ;
                end
            end
            sarg_pkg::ST_SQ:
            begin
                state_next = sarg_pkg::ST_PTS_GO;
            end
            sarg_pkg::ST_PTS_GO:
            begin
                state_next = sarg_pkg::ST_PTS_WAIT;
            end
            sarg_pkg::ST_PTS_WAIT:
            begin
                if (div_done)
                begin
                    state_next = sarg_pkg::ST_DEC;
                end
            end
            sarg_pkg::ST_DEC:
            begin
                if (dec_early || dec_n == 0)
                begin
                    state_next = sarg_pkg::ST_FIN;
                end
                else
                begin
                    state_next = sarg_pkg::ST_PER_GO;
                end
            end
            sarg_pkg::ST_PER_GO:
            begin
                state_next = sarg_pkg::ST_PER_WAIT;
            end
            sarg_pkg::ST_PER_WAIT:
            begin
                if (div_done)
                begin
                    state_next = sarg_pkg::ST_FIN;
                end
            end
            sarg_pkg::ST_FIN:
            begin
                state_next = sarg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sarg_pkg::ST_IDLE;
            end
        endcase
    end

    // Divider launches per state.
    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        case (state_reg)
            sarg_pkg::ST_SPD_GO:
            begin
                div_start = (per_reg != '0);
                div_a     = DN'(SPD_NUM);
                div_b     = DD'(per_reg);
            end
            sarg_pkg::ST_PTS_GO:
            begin
                div_start = 1'b1;
                div_a     = DN'(sq_reg);
                div_b     = DD'(acc2);
            end
            sarg_pkg::ST_PER_GO:
            begin
                div_start = 1'b1;
                div_a     = DN'({per_reg, 1'b0});
                div_b     = DD'(ad);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        pos_next  = pos_reg;
        tgt_next  = tgt_reg;
        per_next  = per_reg;
        idx_next  = idx_reg;
        ela_next  = ela_reg;
        dir_next  = dir_reg;
        busy_next = busy_reg;
        spd_next  = spd_reg;
        sq_next   = sq_reg;
        pts_next  = pts_reg;
        n_next    = n_reg;
        isst_next = isst_reg;
        out_load  = 1'b0;
        done_f    = 1'b0;
        abrt_f    = 1'b0;
        step_f    = 1'b0;
        case (state_reg)
            sarg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        sarg_pkg::OP_START:
                        begin
                            tgt_next  = abs_reg ? amt_w[P-1:0] : pos_reg + amt_w[P-1:0];
                            per_next  = '0;
                            idx_next  = '0;
                            ela_next  = '0;
                            isst_next = 1'b1;
                            if (!en_reg)
                            begin
                                busy_next = 1'b0;
                                done_f    = 1'b1;
                                abrt_f    = 1'b1;
                                out_load  = 1'b1;
                            end
                            else
                            begin
                                busy_next = 1'b1;
                            end
                        end
                        sarg_pkg::OP_STOP:
                        begin
                            out_load = 1'b1;
                            if (busy_reg)
                            begin
                                per_next  = '0;
                                idx_next  = '0;
                                busy_next = 1'b0;
                                done_f    = 1'b1;
                                abrt_f    = 1'b1;
                            end
                        end
                        sarg_pkg::OP_TICK:
                        begin
                            if (busy_reg && !en_reg)
                            begin
                                per_next  = '0;
                                idx_next  = '0;
                                busy_next = 1'b0;
                                done_f    = 1'b1;
                                abrt_f    = 1'b1;
                                out_load  = 1'b1;
                            end
                            else if (busy_reg && step_due)
                            begin
                                pos_next  = dir_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                                ela_next  = '0;
                                isst_next = 1'b0;
                            end
                            else
                            begin
                                if (busy_reg)
                                begin
                                    ela_next = ela_inc;
                                end
                                out_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            sarg_pkg::ST_SPD_GO:
            begin
                if (per_reg == '0)
                begin
                    spd_next = '0;
                end
            end
            sarg_pkg::ST_SPD_WAIT:
            begin
                if (div_done)
                begin
                    spd_next = div_q[sarg_pkg::SPEED_BITS-1:0];
                end
            end
            sarg_pkg::ST_SQ:
            begin
                sq_next = spd_reg * spd_reg;
            end
            sarg_pkg::ST_PTS_WAIT:
            begin
                if (div_done)
                begin
                    pts_next = div_q[SQW-1:0];
                end
            end
            sarg_pkg::ST_DEC:
            begin
                if (dec_early)
                begin
                    per_next = '0;
                    idx_next = '0;
                end
                else if (dec_n == 0)
                begin
                    per_next = {spu, {F{1'b0}}};
                    idx_next = IW'(1);
                    if (tg_neg)
                    begin
                        dir_next = 1'b0;
                    end
                    else if (!tg_zero)
                    begin
                        dir_next = 1'b1;
                    end
                end
                else
                begin
                    n_next = dec_n;
                end
            end
            sarg_pkg::ST_PER_WAIT:
            begin
                if (div_done)
                begin
                    per_next = pnew[PW-1:0];
                    idx_next = (n_reg != sarg_pkg::IDX_MAX) ? n_reg + 1'b1 : n_reg;
                end
            end
            sarg_pkg::ST_FIN:
            begin
                out_load = 1'b1;
                done_f   = 1'b0;
                step_f   = !isst_reg;
                // A zero period ends the move; a step that lands on the
                // target ends it as well.
                if (per_reg == '0 || (!isst_reg && tg_zero))
                begin
                    per_next  = '0;
                    idx_next  = '0;
                    busy_next = 1'b0;
                    done_f    = 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign pos_w = 64'(pos_next);

    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        if (out_load)
        begin
            ov_next = 1'b1;
            od_next = {3'b000, abrt_f, done_f, busy_next, pos_w[31:0], dir_next, step_f};
        end
        else if (m_tready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_reg   <= 1'b0;
            sp_reg    <= 16'd1000;
            mp_reg    <= 16'd100;
            acc_reg   <= AW'(1000);
            en_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sarg_pkg::cfg_idx_t'(cfg_index))
                sarg_pkg::CFG_ABSOLUTE_MODE: abs_reg <= cfg_data[0];
                sarg_pkg::CFG_START_PERIOD:  sp_reg  <= cfg_data[15:0];
                sarg_pkg::CFG_MIN_PERIOD:    mp_reg  <= cfg_data[15:0];
                sarg_pkg::CFG_ACCELERATION:  acc_reg <= cfg_data[AW-1:0];
                sarg_pkg::CFG_DRIVE_ENABLE:  en_reg  <= cfg_data[0];
                default:                     abs_reg <= abs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sarg_pkg::ST_IDLE;
            pos_reg   <= '0;
            tgt_reg   <= '0;
            per_reg   <= '0;
            idx_reg   <= '0;
            ela_reg   <= '0;
            dir_reg   <= 1'b1;
            busy_reg  <= 1'b0;
            isst_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
            per_reg   <= per_next;
            idx_reg   <= idx_next;
            ela_reg   <= ela_next;
            dir_reg   <= dir_next;
            busy_reg  <= busy_next;
            isst_reg  <= isst_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spd_reg <= spd_next;
        sq_reg  <= sq_next;
        pts_reg <= pts_next;
        n_reg   <= n_next;
        od_reg  <= od_next;
    end

endmodule
